// ----- hw/rtl/trms_pkg.sv -----
package trms_pkg;

  localparam int QUEUE_DEPTH   = 256;
  localparam int RELEASE_LIMIT = 16;
  localparam int MIN_BYTES     = 4;
  localparam int MAX_BYTES     = 16;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = $clog2(RELEASE_LIMIT + 1);

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [2:0] KIND_IMM   = 3'd0;
  localparam logic [2:0] KIND_SCHED = 3'd1;
  localparam logic [2:0] KIND_FAR   = 3'd2;
  localparam logic [2:0] KIND_SIZE  = 3'd3;
  localparam logic [2:0] KIND_FULL  = 3'd4;
  localparam logic [2:0] KIND_REL   = 3'd5;
  localparam logic [2:0] KIND_SUM   = 3'd6;

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_IN   = 2'd1;
  localparam logic [1:0] SRC_MEM  = 2'd2;

  localparam logic [1:0] RD_POS = 2'd0;
  localparam logic [1:0] RD_JM1 = 2'd1;
  localparam logic [1:0] RD_K   = 2'd2;
  localparam logic [1:0] RD_I   = 2'd3;

  localparam logic [1:0] REG_MAX_FWD = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_SEND    = 2'd2;
  localparam logic [1:0] REG_DEVICE  = 2'd3;

  typedef struct packed {
    logic [63:0]      ts;
    logic [31:0]      arr;
    logic [7:0]       flags;
    logic [4:0]       bytes;
    logic [3:0][31:0] words;
  } entry_t;

  typedef struct packed {
    logic       latch;
    logic       emit;
    logic [2:0] emit_kind;
    logic [1:0] emit_src;
    logic       emit_last;
    logic       emit_sum;
    logic [1:0] rd_sel;
    logic       arr_set;
    logic       pos_clr;
    logic       pos_inc;
    logic       j_load;
    logic       j_dec;
    logic       wr_shift;
    logic       wr_new;
    logic       k_clr;
    logic       k_inc;
    logic       i_clr;
    logic       i_inc;
    logic       tick_commit;
  } ctl_t;

  typedef struct packed {
    logic       is_tick;
    logic [2:0] dec;
    logic       pos_lt_cnt;
    logic       key_le;
    logic       j_gt_pos;
    logic       k_lt_lim;
    logic       due_ok;
    logic       i_lt_k;
  } sts_t;

  function automatic logic [63:0] due_of(input logic [63:0] ts, input logic [63:0] comp);
    due_of = (ts > comp) ? (ts - comp) : 64'd0;
  endfunction

endpackage

// ----- hw/rtl/trms_ctrl.sv -----
module trms_ctrl import trms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_HRD   = 4'd4;
  localparam logic [3:0] S_HWR   = 4'd5;
  localparam logic [3:0] S_SDONE = 4'd6;
  localparam logic [3:0] S_TRD   = 4'd7;
  localparam logic [3:0] S_TCMP  = 4'd8;
  localparam logic [3:0] S_RRD   = 4'd9;
  localparam logic [3:0] S_ROUT  = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_tick) begin
          ctl.k_clr = 1'b1;
          state_nxt = S_TRD;
        end else if (sts.dec != KIND_SCHED) begin
          ctl.emit      = 1'b1;
          ctl.emit_kind = sts.dec;
          ctl.emit_src  = (sts.dec == KIND_IMM) ? SRC_IN : SRC_ZERO;
          ctl.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctl.arr_set = 1'b1;
          ctl.pos_clr = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.pos_lt_cnt) begin
          ctl.rd_sel = RD_POS;
          state_nxt  = S_SCMP;
        end else begin
          ctl.j_load = 1'b1;
          state_nxt  = S_HRD;
        end
      end
      S_SCMP: begin
        if (sts.key_le) begin
          ctl.pos_inc = 1'b1;
          state_nxt   = S_SRD;
        end else begin
          ctl.j_load = 1'b1;
          state_nxt  = S_HRD;
        end
      end
      S_HRD: begin
        if (sts.j_gt_pos) begin
          ctl.rd_sel = RD_JM1;
          state_nxt  = S_HWR;
        end else begin
          ctl.wr_new = 1'b1;
          state_nxt  = S_SDONE;
        end
      end
      S_HWR: begin
        ctl.wr_shift = 1'b1;
        ctl.j_dec    = 1'b1;
        state_nxt    = S_HRD;
      end
      S_SDONE: begin
        ctl.emit      = 1'b1;
        ctl.emit_kind = KIND_SCHED;
        ctl.emit_src  = SRC_ZERO;
        ctl.emit_last = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_TRD: begin
        if (sts.k_lt_lim) begin
          ctl.rd_sel = RD_K;
          state_nxt  = S_TCMP;
        end else begin
          ctl.i_clr = 1'b1;
          state_nxt = S_RRD;
        end
      end
      S_TCMP: begin
        if (sts.due_ok) begin
          ctl.k_inc = 1'b1;
          state_nxt = S_TRD;
        end else begin
          ctl.i_clr = 1'b1;
          state_nxt = S_RRD;
        end
      end
      S_RRD: begin
        if (sts.i_lt_k) begin
          ctl.rd_sel = RD_I;
          state_nxt  = S_ROUT;
        end else begin
          ctl.rd_sel = RD_K;
          state_nxt  = S_SUM;
        end
      end
      S_ROUT: begin
        ctl.emit      = 1'b1;
        ctl.emit_kind = KIND_REL;
        ctl.emit_src  = SRC_MEM;
        ctl.i_inc     = 1'b1;
        state_nxt     = S_RRD;
      end
      S_SUM: begin
        ctl.emit        = 1'b1;
        ctl.emit_kind   = KIND_SUM;
        ctl.emit_src    = SRC_ZERO;
        ctl.emit_last   = 1'b1;
        ctl.emit_sum    = 1'b1;
        ctl.tick_commit = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/trms_dp.sv -----
module trms_dp import trms_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ctl_t         ctl,
  output sts_t         sts,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_wdata,
  input  logic         in_command,
  input  logic [63:0]  in_now,
  input  logic [63:0]  in_timestamp,
  input  logic [7:0]   in_option_flags,
  input  logic [7:0]   in_byte_count,
  input  logic [31:0]  in_word0,
  input  logic [31:0]  in_word1,
  input  logic [31:0]  in_word2,
  input  logic [31:0]  in_word3,
  output logic         out_valid,
  output logic [2:0]   out_kind,
  output logic [63:0]  out_timestamp,
  output logic [7:0]   out_flags,
  output logic [7:0]   out_byte_count,
  output logic [31:0]  out_word0,
  output logic [31:0]  out_word1,
  output logic [31:0]  out_word2,
  output logic [31:0]  out_word3,
  output logic [63:0]  out_next_due_time,
  output logic [8:0]   out_queue_count,
  output logic         out_last
);

  logic [47:0] max_fwd_r;
  logic [31:0] window_r, send_r, device_r;

  logic             cmd_r;
  logic [63:0]      now_r, ts_r;
  logic [7:0]       flags_r, bytes_r;
  logic [3:0][31:0] words_r;

  entry_t          mem [QUEUE_DEPTH];
  entry_t          rdata_r;
  logic [AW-1:0]   head_r, rd_addr, wr_addr;
  logic [CW-1:0]   held_r, pos_r, j_r;
  logic [KW-1:0]   k_r, i_r;
  logic [31:0]     arr_r;
  entry_t          new_entry, wr_data;
  logic            wr_en;

  logic [63:0] fwd_gap, win, comp;
  logic [2:0]  dec;

  logic             valid_r;
  logic [2:0]       kind_r;
  logic [63:0]      ots_r, next_r;
  logic [7:0]       oflags_r, obytes_r;
  logic [3:0][31:0] owords_r;
  logic [CW-1:0]    ocnt_r;
  logic             last_r;

  logic [63:0]      e_ts;
  logic [7:0]       e_flags, e_bytes;
  logic [3:0][31:0] e_words;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fwd_r <= '0;
      window_r  <= '0;
      send_r    <= '0;
      device_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_FWD: max_fwd_r <= cfg_wdata;
        REG_WINDOW:  window_r  <= cfg_wdata[31:0];
        REG_SEND:    send_r    <= cfg_wdata[31:0];
        REG_DEVICE:  device_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= in_command;
      now_r   <= in_now;
      ts_r    <= in_timestamp;
      flags_r <= in_option_flags;
      bytes_r <= in_byte_count;
      words_r <= {in_word3, in_word2, in_word1, in_word0};
    end
  end

  // submit decision
  always_comb begin
    fwd_gap = ts_r - now_r;
    win  = {31'd0, {1'b0, window_r} + {1'b0, device_r}};
    comp = {31'd0, {1'b0, send_r} + {1'b0, device_r}};
    if (ts_r == 64'd0 || ts_r <= now_r) begin
      dec = KIND_IMM;
    end else if (fwd_gap > {16'd0, max_fwd_r}) begin
      dec = KIND_FAR;
    end else if (fwd_gap <= win) begin
      dec = KIND_IMM;
    end else if (bytes_r < 8'(MIN_BYTES) || bytes_r > 8'(MAX_BYTES)) begin
      dec = KIND_SIZE;
    end else if (held_r == CW'(QUEUE_DEPTH)) begin
      dec = KIND_FULL;
    end else begin
      dec = KIND_SCHED;
    end
  end

  always_comb begin
    case (ctl.rd_sel)
      RD_POS:  rd_addr = head_r + pos_r[AW-1:0];
      RD_JM1:  rd_addr = head_r + AW'(j_r - 1'b1);
      RD_K:    rd_addr = head_r + AW'(k_r);
      default: rd_addr = head_r + AW'(i_r);
    endcase
    new_entry.ts    = ts_r;
    new_entry.arr   = arr_r;
    new_entry.flags = flags_r;
    new_entry.bytes = bytes_r[4:0];
    new_entry.words = words_r;
    wr_en   = ctl.wr_shift | ctl.wr_new;
    wr_addr = ctl.wr_new ? (head_r + pos_r[AW-1:0]) : (head_r + j_r[AW-1:0]);
    wr_data = ctl.wr_new ? new_entry : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
      arr_r  <= '0;
    end else begin
      if (ctl.arr_set) begin
        arr_r <= (held_r == '0) ? 32'd0 : arr_r + 32'd1;
      end
      if (ctl.wr_new) begin
        held_r <= held_r + 1'b1;
      end else if (ctl.tick_commit) begin
        head_r <= head_r + AW'(k_r);
        held_r <= held_r - CW'(k_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pos_clr) begin
      pos_r <= '0;
    end else if (ctl.pos_inc) begin
      pos_r <= pos_r + 1'b1;
    end
    if (ctl.j_load) begin
      j_r <= held_r;
    end else if (ctl.j_dec) begin
      j_r <= j_r - 1'b1;
    end
    if (ctl.k_clr) begin
      k_r <= '0;
    end else if (ctl.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (ctl.i_clr) begin
      i_r <= '0;
    end else if (ctl.i_inc) begin
      i_r <= i_r + 1'b1;
    end
  end

  always_comb begin
    sts.is_tick    = (cmd_r == CMD_TICK);
    sts.dec        = dec;
    sts.pos_lt_cnt = (pos_r < held_r);
    sts.key_le     = (rdata_r.ts < ts_r) || (rdata_r.ts == ts_r && rdata_r.arr <= arr_r);
    sts.j_gt_pos   = (j_r > pos_r);
    sts.k_lt_lim   = (CW'(k_r) < held_r) && (k_r < KW'(RELEASE_LIMIT));
    sts.due_ok     = (due_of(rdata_r.ts, comp) <= now_r);
    sts.i_lt_k     = (i_r < k_r);
  end

  always_comb begin
    case (ctl.emit_src)
      SRC_IN: begin
        e_ts    = ts_r;
        e_flags = flags_r;
        e_bytes = bytes_r;
        e_words = words_r;
      end
      SRC_MEM: begin
        e_ts    = rdata_r.ts;
        e_flags = rdata_r.flags;
        e_bytes = {3'd0, rdata_r.bytes};
        e_words = rdata_r.words;
      end
      default: begin
        e_ts    = '0;
        e_flags = '0;
        e_bytes = '0;
        e_words = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      kind_r   <= ctl.emit_kind;
      ots_r    <= e_ts;
      oflags_r <= e_flags;
      obytes_r <= e_bytes;
      for (int w = 0; w < 4; w++) begin
        owords_r[w] <= ({2'd0, e_bytes} > 10'(4 * w)) ? e_words[w] : 32'd0;
      end
      next_r   <= (ctl.emit_sum && held_r != CW'(k_r)) ? due_of(rdata_r.ts, comp) : 64'd0;
      ocnt_r   <= (cmd_r == CMD_TICK) ? (held_r - CW'(k_r)) : held_r;
      last_r   <= ctl.emit_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_timestamp     = ots_r;
  assign out_flags         = oflags_r;
  assign out_byte_count    = obytes_r;
  assign out_word0         = owords_r[0];
  assign out_word1         = owords_r[1];
  assign out_word2         = owords_r[2];
  assign out_word3         = owords_r[3];
  assign out_next_due_time = next_r;
  assign out_queue_count   = 9'(ocnt_r);
  assign out_last          = last_r;

endmodule

// ----- hw/rtl/timed_release_message_scheduler_top.sv -----
// Timed-release message scheduler. Raise start while busy is low to hand in one request:
// a submit (in_command 0) or a tick (in_command 1). Every result appears for one cycle with
// out_valid high and must be taken then; out_last marks the final result of a request.
// Entries sit in a circular memory with one read and one write port, in timestamp order. A
// submit decided at once ends in the decode state; a stored one first searches the held
// entries from the head, then moves each later entry up one place and writes the new one.
// A tick checks held entries from the head, at most RELEASE_LIMIT of them, then sends each
// released entry out and ends with a summary. Each result leaves through an output
// register in the cycle after the state that makes it. Configuration writes are registered
// and are meant for when busy is low.
module timed_release_message_scheduler_top import trms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_command,
  input  logic [63:0] in_now,
  input  logic [63:0] in_timestamp,
  input  logic [7:0]  in_option_flags,
  input  logic [7:0]  in_byte_count,
  input  logic [31:0] in_word0,
  input  logic [31:0] in_word1,
  input  logic [31:0] in_word2,
  input  logic [31:0] in_word3,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [63:0] out_timestamp,
  output logic [7:0]  out_flags,
  output logic [7:0]  out_byte_count,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3,
  output logic [63:0] out_next_due_time,
  output logic [8:0]  out_queue_count,
  output logic        out_last
);

  ctl_t ctl;
  sts_t sts;

  trms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  trms_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_now            (in_now),
    .in_timestamp      (in_timestamp),
    .in_option_flags   (in_option_flags),
    .in_byte_count     (in_byte_count),
    .in_word0          (in_word0),
    .in_word1          (in_word1),
    .in_word2          (in_word2),
    .in_word3          (in_word3),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_timestamp     (out_timestamp),
    .out_flags         (out_flags),
    .out_byte_count    (out_byte_count),
    .out_word0         (out_word0),
    .out_word1         (out_word1),
    .out_word2         (out_word2),
    .out_word3         (out_word3),
    .out_next_due_time (out_next_due_time),
    .out_queue_count   (out_queue_count),
    .out_last          (out_last)
  );

endmodule

// ----- tb/tb_timed_release_message_scheduler_top.sv -----
`timescale 1ns / 1ps

module tb_timed_release_message_scheduler_top;
  import trms_pkg::*;

  typedef struct packed {
    logic             cmd;
    logic [63:0]      now;
    logic [63:0]      ts;
    logic [7:0]       flags;
    logic [7:0]       bytes;
    logic [3:0][31:0] words;
  } request_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [63:0]      ts;
    logic [7:0]       flags;
    logic [7:0]       bytes;
    logic [3:0][31:0] words;
    logic [63:0]      next_due;
    logic [8:0]       count;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [63:0]      ts;
    logic [31:0]      arr;
    logic [7:0]       flags;
    logic [4:0]       bytes;
    logic [3:0][31:0] words;
  } held_msg_t;

  typedef struct packed {
    request_t   req;
    logic       typed;
    logic [2:0] kind;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  logic        in_command = 1'b0;
  logic [63:0] in_now = '0;
  logic [63:0] in_timestamp = '0;
  logic [7:0]  in_option_flags = '0;
  logic [7:0]  in_byte_count = '0;
  logic [31:0] in_word0 = '0;
  logic [31:0] in_word1 = '0;
  logic [31:0] in_word2 = '0;
  logic [31:0] in_word3 = '0;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [63:0] out_timestamp;
  logic [7:0]  out_flags;
  logic [7:0]  out_byte_count;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;
  logic [63:0] out_next_due_time;
  logic [8:0]  out_queue_count;
  logic        out_last;

  timed_release_message_scheduler_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [47:0] max_fwd_q;
  logic [31:0] window_q;
  logic [31:0] send_lat_q;
  logic [31:0] dev_lat_q;
  logic [31:0] arrival_q;
  held_msg_t   held_q[$];
  result_t     pending_results[$];
  dir_row_t    dir_table[$];

  int          mismatches = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          kind_seen[7];
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] base_now = 64'd1000;

  function automatic logic [63:0] comp_due(logic [63:0] ts, logic [63:0] comp);
    return (ts > comp) ? ts - comp : 64'd0;
  endfunction

  function automatic logic [3:0][31:0] trim_words(logic [3:0][31:0] w, logic [7:0] n);
    logic [3:0][31:0] r;
    for (int i = 0; i < 4; i++) r[i] = (4 * i < n) ? w[i] : 32'd0;
    return r;
  endfunction

  function automatic result_t refusal(logic [2:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    r.count = 9'(held_q.size());
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_row(dir_row_t d);
    dir_table = {dir_table, d};
  endtask

  task automatic predict_request(request_t q);
    result_t     r;
    held_msg_t   m;
    logic [63:0] fwd_gap;
    logic [63:0] comp;
    int          pos;
    int          k;
    if (q.cmd == CMD_SUBMIT) begin
      fwd_gap = q.ts - q.now;
      if (q.ts == 64'd0 || q.ts <= q.now ||
          (fwd_gap <= 64'(max_fwd_q) && fwd_gap <= 64'(window_q) + 64'(dev_lat_q))) begin
        r = refusal(KIND_IMM);
        r.ts = q.ts;
        r.flags = q.flags;
        r.bytes = q.bytes;
        r.words = trim_words(q.words, q.bytes);
      end else if (fwd_gap > 64'(max_fwd_q)) begin
        r = refusal(KIND_FAR);
      end else if (q.bytes < MIN_BYTES || q.bytes > MAX_BYTES) begin
        r = refusal(KIND_SIZE);
      end else if (held_q.size() >= QUEUE_DEPTH) begin
        r = refusal(KIND_FULL);
      end else begin
        arrival_q = (held_q.size() == 0) ? 32'd0 : arrival_q + 32'd1;
        m.ts = q.ts;
        m.arr = arrival_q;
        m.flags = q.flags;
        m.bytes = q.bytes[4:0];
        m.words = q.words;
        pos = 0;
        while (pos < held_q.size() && (held_q[pos].ts < q.ts ||
               (held_q[pos].ts == q.ts && held_q[pos].arr <= arrival_q)))
          pos++;
        held_q.insert(pos, m);
        r = refusal(KIND_SCHED);
      end
      pending_results = {pending_results, r};
    end else begin
      comp = 64'(dev_lat_q) + 64'(send_lat_q);
      k = 0;
      while (held_q.size() > 0 && k < RELEASE_LIMIT &&
             comp_due(held_q[0].ts, comp) <= q.now) begin
        m = held_q.pop_front();
        r = '0;
        r.kind = KIND_REL;
        r.ts = m.ts;
        r.flags = m.flags;
        r.bytes = 8'(m.bytes);
        r.words = trim_words(m.words, 8'(m.bytes));
        pending_results = {pending_results, r};
        k++;
      end
      for (int i = pending_results.size() - k; i < pending_results.size(); i++)
        pending_results[i].count = 9'(held_q.size());
      r = refusal(KIND_SUM);
      if (held_q.size() > 0) r.next_due = comp_due(held_q[0].ts, comp);
      pending_results = {pending_results, r};
    end
  endtask

  task automatic drive_request(request_t q);
    in_command <= q.cmd;
    in_now <= q.now;
    in_timestamp <= q.ts;
    in_option_flags <= q.flags;
    in_byte_count <= q.bytes;
    in_word0 <= q.words[0];
    in_word1 <= q.words[1];
    in_word2 <= q.words[2];
    in_word3 <= q.words[3];
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    predict_request(q);
    requests_sent++;
  endtask

  task automatic sender_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_request(request_t q);
    drive_request(q);
    sender_idle();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MAX_FWD: max_fwd_q = val;
      REG_WINDOW:  window_q = val[31:0];
      REG_SEND:    send_lat_q = val[31:0];
      default:     dev_lat_q = val[31:0];
    endcase
  endtask

  task automatic write_all(logic [47:0] fwd, logic [31:0] win, logic [31:0] snd,
                           logic [31:0] dev);
    write_reg(REG_MAX_FWD, fwd);
    write_reg(REG_WINDOW, 48'(win));
    write_reg(REG_SEND, 48'(snd));
    write_reg(REG_DEVICE, 48'(dev));
  endtask

  function automatic request_t mk_req(logic cmd, logic [63:0] now, logic [63:0] ts,
                                      logic [7:0] fl, logic [7:0] nb, logic [31:0] w);
    request_t q;
    q.cmd = cmd;
    q.now = now;
    q.ts = ts;
    q.flags = fl;
    q.bytes = nb;
    q.words = {~w, w ^ 32'h5A5A5A5A, ~w ^ 32'h0F0F0F0F, w};
    return q;
  endfunction

  function automatic dir_row_t mk_row(request_t q, logic typed, logic [2:0] k);
    dir_row_t d;
    d.req = q;
    d.typed = typed;
    d.kind = k;
    return d;
  endfunction

  function automatic logic [3:0][31:0] rand_words();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic request_t rand_request();
    request_t    q;
    logic [63:0] win;
    int          pick;
    win = 64'(window_q) + 64'(dev_lat_q);
    q.flags = 8'($urandom);
    q.bytes = 8'($urandom_range(MIN_BYTES, MAX_BYTES));
    q.words = rand_words();
    pick = $urandom_range(99);
    if (pick < 30) begin
      base_now = base_now + 64'($urandom_range(0, 400));
      q.cmd = CMD_TICK;
      q.now = base_now;
      q.ts = {$urandom, $urandom};
    end else begin
      q.cmd = CMD_SUBMIT;
      q.now = base_now;
      if (pick < 36) q.ts = (pick < 33) ? 64'd0 : base_now - 64'($urandom_range(0, 50));
      else if (pick < 42) q.ts = base_now + 64'($urandom_range(1, 40)) % (win + 64'd1);
      else if (pick < 46) q.ts = base_now + 64'(max_fwd_q) + 64'($urandom_range(1, 3));
      else if (pick < 50) begin
        q.now = {$urandom, $urandom};
        q.ts = {$urandom, $urandom};
        q.bytes = 8'($urandom);
      end else begin
        q.ts = base_now + win + 64'($urandom_range(1, 2000));
        if (pick < 55) q.bytes = 8'($urandom);
      end
    end
    return q;
  endfunction

  // result checking and watchdog
  always @(posedge clk) begin
    result_t act;
    result_t exp_r;
    if ((start && !busy) || (rst_n && out_valid)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_kind < 7) kind_seen[out_kind]++;
      act.kind = out_kind;
      act.ts = out_timestamp;
      act.flags = out_flags;
      act.bytes = out_byte_count;
      act.words = {out_word3, out_word2, out_word1, out_word0};
      act.next_due = out_next_due_time;
      act.count = out_queue_count;
      act.last = out_last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind %0d", out_kind);
      end else begin
        exp_r = pending_results.pop_front();
        if (act !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp kind %0d ts %h fl %h nb %0d w %h due %h cnt %0d last %b",
                     exp_r.kind, exp_r.ts, exp_r.flags, exp_r.bytes, exp_r.words,
                     exp_r.next_due, exp_r.count, exp_r.last);
            $display("          got kind %0d ts %h fl %h nb %0d w %h due %h cnt %0d last %b",
                     act.kind, act.ts, act.flags, act.bytes, act.words, act.next_due,
                     act.count, act.last);
          end
        end
      end
    end
    if (quiet_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    request_t q;
    int       n;
    max_fwd_q = '0;
    window_q = '0;
    send_lat_q = '0;
    dev_lat_q = '0;
    arrival_q = '0;
    foreach (kind_seen[i]) kind_seen[i] = 0;

    add_row(mk_row(mk_req(CMD_TICK, 64'd0, 64'd0, 8'h00, 8'd0, 32'd0),
                   1'b1, KIND_SUM));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd0, 64'd0, 8'hFF, 8'd16,
                   32'hFFFFFFFF), 1'b0, KIND_IMM));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd5, 64'd5, 8'h81, 8'd0, 32'h1234),
                   1'b0, KIND_IMM));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd0, '1, 8'h01, 8'd4, 32'h1),
                   1'b1, KIND_FAR));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd105, 8'h3C, 8'd200,
                   32'hCAFE0001), 1'b0, KIND_IMM));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd200, 8'h11, 8'd3, 32'h2),
                   1'b1, KIND_SIZE));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd200, 8'h22, 8'd17, 32'h3),
                   1'b1, KIND_SIZE));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd200, 8'h33, 8'd0, 32'h4),
                   1'b1, KIND_SIZE));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd200, 8'h44, 8'd255, 32'h5),
                   1'b1, KIND_SIZE));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd200, 8'h00, 8'd4,
                   32'hA5A5A5A5), 1'b0, KIND_SCHED));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd150, 8'hFF, 8'd16,
                   32'hFFFFFFFF), 1'b0, KIND_SCHED));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'd200, 8'h7E, 8'd7,
                   32'h00000000), 1'b0, KIND_SCHED));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'hFFFFFFFFFFFF + 64'd100,
                   8'h80, 8'd13, 32'h13579BDF), 1'b0, KIND_SCHED));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'd100, 64'h1000000000000 + 64'd100,
                   8'h01, 8'd8, 32'h6), 1'b1, KIND_FAR));
    add_row(mk_row(mk_req(CMD_TICK, 64'd0, 64'd0, 8'h00, 8'd0, 32'd0),
                   1'b0, KIND_SUM));
    add_row(mk_row(mk_req(CMD_TICK, 64'd142, 64'd0, 8'h00, 8'd0, 32'd0),
                   1'b0, KIND_SUM));
    add_row(mk_row(mk_req(CMD_TICK, 64'd192, 64'd0, 8'h00, 8'd0, 32'd0),
                   1'b0, KIND_SUM));
    add_row(mk_row(mk_req(CMD_TICK, '1, 64'd0, 8'h00, 8'd0, 32'd0),
                   1'b0, KIND_SUM));
    add_row(mk_row(mk_req(CMD_SUBMIT, '1, '1, 8'hFF, 8'd255, 32'hFFFFFFFF),
                   1'b0, KIND_IMM));
    add_row(mk_row(mk_req(CMD_SUBMIT, 64'hFFFFFFFFFFFFFFF0, '1, 8'h5A, 8'd9,
                   32'h89ABCDEF), 1'b0, KIND_SCHED));
    add_row(mk_row(mk_req(CMD_TICK, '1, 64'd0, 8'h00, 8'd0, 32'd0),
                   1'b0, KIND_SUM));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 23;
    foreach (dir_table[r]) begin
      if (r == 4) write_all(48'hFFFFFFFFFFFF, 32'd10, 32'd5, 32'd3);
      drive_request(dir_table[r].req);
      // typed-in kind for the final result of this request
      if (dir_table[r].typed)
        pending_results[pending_results.size() - 1].kind = dir_table[r].kind;
      sender_idle();
    end

    // fill to capacity, then drain under the release limit
    write_all(48'd1000000, 32'd0, 32'd0, 32'd0);
    idle_pct = 0;
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      q = mk_req(CMD_SUBMIT, base_now, base_now + 64'd100 + 64'($urandom_range(0, 40)),
                 8'($urandom), 8'($urandom_range(MIN_BYTES, MAX_BYTES)), $urandom);
      q.words = rand_words();
      send_request(q);
    end
    for (int i = 0; i <= QUEUE_DEPTH / RELEASE_LIMIT; i++)
      send_request(mk_req(CMD_TICK, base_now + 64'd1000, 64'd0, 8'd0, 8'd0, 32'd0));
    base_now = base_now + 64'd1000;

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 23 : (ph < 4) ? 69 : 0;
      case (ph)
        1: write_all(48'hFFFFFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        3: write_all(48'd0, 32'hFFFFFFFF, 32'd0, 32'd0);
        default: write_all(48'($urandom_range(2000, 6000)), $urandom_range(0, 300),
                           $urandom_range(0, 300), $urandom_range(0, 300));
      endcase
      n = 0;
      while (n < 6) begin
        q = rand_request();
        send_request(q);
        n++;
      end
      // flush held entries between settings
      send_request(mk_req(CMD_TICK, '1, 64'd0, 8'd0, 8'd0, 32'd0));
      while (held_q.size() != 0)
        send_request(mk_req(CMD_TICK, '1, 64'd0, 8'd0, 8'd0, 32'd0));
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    $display("%0d requests, %0d results: imm %0d sched %0d far %0d size %0d full %0d",
             requests_sent, results_seen, kind_seen[0], kind_seen[1], kind_seen[2],
             kind_seen[3], kind_seen[4]);
    $display("released %0d, tick summaries %0d, mismatches %0d",
             kind_seen[5], kind_seen[6], mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
